@@ hdl/canonical_huffman_bit_decoder_defines.svh @@
// Assertion macros used by the decoder checker.
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_DEFINES_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define CHBD_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/chbd_pkg.sv @@
// Shared types and constants of the canonical Huffman bit decoder.
`timescale 1ns / 1ps

package chbd_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_BITS  = 9;
  localparam int KIND_BITS    = 3;
  localparam int LEN_BITS     = 5;
  localparam int COUNT_BITS   = 10;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_CLEAR     = 3'd0,
    KIND_SET_COUNT = 3'd1,
    KIND_APPEND    = 3'd2,
    KIND_BIT       = 3'd3,
    KIND_RESTART   = 3'd4
  } kind_e;

endpackage

@@ hdl/canonical_huffman_bit_decoder.sv @@
// Canonical Huffman decoder: count table, symbol memory and bit walk.
`timescale 1ns / 1ps

// One beat is accepted per cycle while in_ready_o is high; each beat yields
// one result beat. The rate is set by the walk registers (partial code, first
// code, base index, depth), which update in the cycle a bit is accepted, and
// by the symbol memory, whose registered read supplies the matched symbol in
// the next cycle. Result and output stages let one more beat enter while a
// result waits. Tables load through the same channel: clear, set the count of
// a length, append symbols in canonical order. The count table is in
// flip-flops and clears at once; the symbol memory needs no clearing pass.
module canonical_huffman_bit_decoder #(
  parameter int MAX_CODE_LEN = chbd_pkg::MAX_CODE_LEN,
  parameter int SYMBOL_BITS  = chbd_pkg::SYMBOL_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [chbd_pkg::KIND_BITS-1:0]      kind_i,
  input  logic [chbd_pkg::LEN_BITS-1:0]       code_length_i,
  input  logic [chbd_pkg::COUNT_BITS-1:0]     length_count_i,
  input  logic [SYMBOL_BITS-1:0]              symbol_in_i,
  input  logic                                code_bit_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                symbol_ready_o,
  output logic [SYMBOL_BITS-1:0]              symbol_out_o,
  output logic                                bad_code_o
);

  localparam int CW    = chbd_pkg::COUNT_BITS;
  localparam int FW    = MAX_CODE_LEN + 1;
  localparam int BW    = $clog2(MAX_CODE_LEN + 1);
  localparam int LW    = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int LDW   = SYMBOL_BITS + 1;
  localparam int DEPTH = 1 << SYMBOL_BITS;
  localparam int XM0   = (FW > CW) ? FW : CW;
  localparam int XM1   = (XM0 > LDW) ? XM0 : LDW;
  localparam int XW    = XM1 + 1;
  localparam int SW    = XW + 2;

  // Tables.
  logic [CW-1:0]          count_q [MAX_CODE_LEN];
  logic [SYMBOL_BITS-1:0] sym_mem [DEPTH];
  logic [SYMBOL_BITS-1:0] mem_rdata_q;
  logic [LDW-1:0]         loaded_q, loaded_d;

  // Walk state.
  logic [FW-1:0] partial_q, partial_d;
  logic [FW-1:0] first_q, first_d;
  logic [BW-1:0] bits_q, bits_d;
  logic [CW-1:0] base_q, base_d;

  // Result and output stages.
  logic                   a_valid_q, a_ready_q, a_bad_q;
  logic                   o_valid_q, o_ready_q, o_bad_q;
  logic [SYMBOL_BITS-1:0] o_sym_q;

  logic                   accept, a_move;
  logic                   res_ready, res_bad;
  logic                   clear_all, cnt_we, sym_we;
  logic [LW-1:0]          cnt_waddr;
  logic [FW-1:0]          code;
  logic [BW-1:0]          depth;
  logic [CW-1:0]          count_cur;
  logic [FW-1:0]          diff;
  logic [XW-1:0]          diff_x, count_x, idx, nb_x;
  logic [CW:0]            nb_sum;
  logic [CW-1:0]          nb;
  logic [SW-1:0]          nf_sum, nf_w;
  logic [FW-1:0]          nf;
  logic                   hit;

  assign a_move     = a_valid_q && (!o_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_move;
  assign accept     = in_valid_i && in_ready_o;

  // Walk datapath for one decode bit.
  assign code      = {partial_q[FW-2:0], code_bit_i};
  assign depth     = bits_q + BW'(1);
  assign count_cur = count_q[bits_q[LW-1:0]];
  assign diff      = code - first_q;
  assign diff_x    = XW'(diff);
  assign count_x   = XW'(count_cur);
  assign hit       = (code >= first_q) && (diff_x < count_x);
  assign idx       = XW'(base_q) + diff_x;

  assign nb_sum = {1'b0, base_q} + {1'b0, count_cur};
  assign nb     = nb_sum[CW] ? {CW{1'b1}} : nb_sum[CW-1:0];
  assign nb_x   = XW'(nb);
  assign nf_sum = SW'(first_q) + SW'(count_cur);
  assign nf_w   = nf_sum << 1;
  assign nf     = (nf_w > SW'({FW{1'b1}})) ? {FW{1'b1}} : nf_w[FW-1:0];

  always_comb begin
    partial_d = partial_q;
    first_d   = first_q;
    bits_d    = bits_q;
    base_d    = base_q;
    loaded_d  = loaded_q;
    res_ready = 1'b0;
    res_bad   = 1'b0;
    clear_all = 1'b0;
    cnt_we    = 1'b0;
    sym_we    = 1'b0;
    cnt_waddr = LW'(code_length_i - chbd_pkg::LEN_BITS'(1));
    case (kind_i)
      chbd_pkg::KIND_CLEAR: begin
        clear_all = 1'b1;
        loaded_d  = '0;
        partial_d = '0;
        first_d   = '0;
        bits_d    = '0;
        base_d    = '0;
      end
      chbd_pkg::KIND_SET_COUNT: begin
        cnt_we    = (code_length_i != '0) && (32'(code_length_i) <= MAX_CODE_LEN);
        partial_d = '0;
        first_d   = '0;
        bits_d    = '0;
        base_d    = '0;
      end
      chbd_pkg::KIND_APPEND: begin
        if (!loaded_q[LDW-1]) begin
          sym_we   = 1'b1;
          loaded_d = loaded_q + LDW'(1);
        end
        partial_d = '0;
        first_d   = '0;
        bits_d    = '0;
        base_d    = '0;
      end
      chbd_pkg::KIND_BIT: begin
        if (hit) begin
          if (idx < XW'(loaded_q)) begin
            res_ready = 1'b1;
          end else begin
            res_bad = 1'b1;
          end
          partial_d = '0;
          first_d   = '0;
          bits_d    = '0;
          base_d    = '0;
        end else if ((32'(depth) >= MAX_CODE_LEN) || (nb_x >= XW'(loaded_q))) begin
          // No code can complete from here: flag and restart.
          res_bad   = 1'b1;
          partial_d = '0;
          first_d   = '0;
          bits_d    = '0;
          base_d    = '0;
        end else begin
          partial_d = code;
          first_d   = nf;
          bits_d    = depth;
          base_d    = nb;
        end
      end
      chbd_pkg::KIND_RESTART: begin
        partial_d = '0;
        first_d   = '0;
        bits_d    = '0;
        base_d    = '0;
      end
      default: begin
      end
    endcase
  end

  // Count table: cleared at once by a clear beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        count_q[i] <= '0;
      end
    end else if (accept && clear_all) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        count_q[i] <= '0;
      end
    end else if (accept && cnt_we) begin
      count_q[cnt_waddr] <= length_count_i;
    end
  end

  // Symbol memory: write on append, registered read on every accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept && sym_we) begin
      sym_mem[loaded_q[SYMBOL_BITS-1:0]] <= symbol_in_i;
    end
    if (accept) begin
      mem_rdata_q <= sym_mem[idx[SYMBOL_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      partial_q <= '0;
      first_q   <= '0;
      bits_q    <= '0;
      base_q    <= '0;
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        loaded_q  <= loaded_d;
        partial_q <= partial_d;
        first_q   <= first_d;
        bits_q    <= bits_d;
        base_q    <= base_d;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads: hold while the next stage stalls.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ready_q <= res_ready;
      a_bad_q   <= res_bad;
    end
    if (a_move) begin
      o_ready_q <= a_ready_q;
      o_bad_q   <= a_bad_q;
      o_sym_q   <= a_ready_q ? mem_rdata_q : '0;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign symbol_ready_o = o_ready_q;
  assign symbol_out_o   = o_sym_q;
  assign bad_code_o     = o_bad_q;

endmodule

@@ hdl/chbd_checker.sv @@
// Port-level checks of the canonical Huffman bit decoder, bound to the top level.
`timescale 1ns / 1ps
`include "canonical_huffman_bit_decoder_defines.svh"

module chbd_checker #(
  parameter int SYMBOL_BITS = chbd_pkg::SYMBOL_BITS
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                symbol_ready_o,
  input logic [SYMBOL_BITS-1:0]              symbol_out_o,
  input logic                                bad_code_o
);

  logic out_stall;
  assign out_stall = out_valid_o && !out_ready_i;

  // The input side only backs up behind a waiting result beat.
  `CHBD_ASSERT(a_ready_only_on_stall, clk_i, rst_ni,
               in_ready_o || out_valid_o, "input stalled with no result waiting")
  // A beat is either a symbol or a bad code, never both.
  `CHBD_ASSERT(a_flags_exclusive, clk_i, rst_ni,
               !(out_valid_o && symbol_ready_o && bad_code_o), "symbol and bad code in one beat")
  // No symbol value leaks into a beat without a symbol.
  `CHBD_ASSERT(a_symbol_zero, clk_i, rst_ni,
               !(out_valid_o && !symbol_ready_o) || (symbol_out_o == '0),
               "symbol field set without symbol")
  // A stalled result beat holds.
  `CHBD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
                    out_valid_o && $stable(symbol_out_o) && $stable(symbol_ready_o)
                    && $stable(bad_code_o), "result beat changed while stalled")

endmodule

bind canonical_huffman_bit_decoder chbd_checker #(.SYMBOL_BITS(SYMBOL_BITS)) u_chbd_checker (.*);

@@ tb/canonical_huffman_bit_decoder_tb.sv @@
// Self-checking testbench for the canonical Huffman bit decoder.
`timescale 1ns / 1ps

module canonical_huffman_bit_decoder_tb;

  localparam int MAX_CODE_LEN = chbd_pkg::MAX_CODE_LEN;
  localparam int SYMBOL_BITS = chbd_pkg::SYMBOL_BITS;
  localparam int KIND_BITS = chbd_pkg::KIND_BITS;
  localparam int LEN_BITS = chbd_pkg::LEN_BITS;
  localparam int COUNT_BITS = chbd_pkg::COUNT_BITS;
  localparam int TABLE_DEPTH = 1 << SYMBOL_BITS;
  localparam int WALK_BITS = MAX_CODE_LEN + 1;
  localparam longint unsigned FIRST_CAP = (longint'(1) << WALK_BITS) - 1;
  localparam longint unsigned BASE_CAP = (1 << COUNT_BITS) - 1;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED_HI = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_TAIL = 10;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LEN_BITS-1:0]    len;
    logic [COUNT_BITS-1:0]  cnt;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   code_bit;
  } beat_t;

  typedef struct packed {
    logic                   sym_ready;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   bad;
  } result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [KIND_BITS-1:0]   kind_i;
  logic [LEN_BITS-1:0]    code_length_i;
  logic [COUNT_BITS-1:0]  length_count_i;
  logic [SYMBOL_BITS-1:0] symbol_in_i;
  logic                   code_bit_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   symbol_ready_o;
  logic [SYMBOL_BITS-1:0] symbol_out_o;
  logic                   bad_code_o;

  canonical_huffman_bit_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .code_length_i  (code_length_i),
    .length_count_i (length_count_i),
    .symbol_in_i    (symbol_in_i),
    .code_bit_i     (code_bit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_ready_o (symbol_ready_o),
    .symbol_out_o   (symbol_out_o),
    .bad_code_o     (bad_code_o)
  );

  // Decoder state as predicted from the accepted beats.
  logic [COUNT_BITS-1:0]  len_count [MAX_CODE_LEN];
  logic [SYMBOL_BITS-1:0] sym_table [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]  sym_loaded;
  logic [WALK_BITS-1:0]   walk_code;
  logic [WALK_BITS-1:0]   walk_first;
  logic [LEN_BITS-1:0]    walk_depth;
  logic [COUNT_BITS-1:0]  walk_base;

  result_t expected_decodes [$];
  int fail_count = 0;
  int beats_sent = 0;
  int src_idle_pct = 27;
  int sink_idle_pct = 64;
  int sink_hold_cycles = 0;

  // Code table the stimulus encodes against, indexed by code length.
  int gen_count [1:MAX_CODE_LEN] = '{default: 0};
  int gen_codes = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void restart_walk();
    walk_code = '0;
    walk_first = '0;
    walk_depth = '0;
    walk_base = '0;
  endfunction

  function automatic void clear_tables();
    foreach (len_count[n]) len_count[n] = '0;
    sym_loaded = '0;
    restart_walk();
  endfunction

  function automatic result_t decode_step(input beat_t b);
    result_t r;
    longint unsigned code, cnt, nf, nb, idx;
    int unsigned depth;
    r = '0;
    case (b.kind)
      chbd_pkg::KIND_CLEAR: clear_tables();
      chbd_pkg::KIND_SET_COUNT: begin
        if (b.len >= 1 && b.len <= MAX_CODE_LEN) len_count[b.len - 1] = b.cnt;
        restart_walk();
      end
      chbd_pkg::KIND_APPEND: begin
        // drop appends once the table is full
        if (sym_loaded < TABLE_DEPTH) begin
          sym_table[sym_loaded[SYMBOL_BITS-1:0]] = b.sym;
          sym_loaded = sym_loaded + 1'b1;
        end
        restart_walk();
      end
      chbd_pkg::KIND_BIT: begin
        code = {walk_code, b.code_bit};
        depth = walk_depth + 1;
        if (depth > MAX_CODE_LEN) depth = MAX_CODE_LEN;
        cnt = len_count[depth - 1];
        if (code >= walk_first && code - walk_first < cnt) begin
          idx = walk_base + (code - walk_first);
          if (idx < sym_loaded) begin
            r.sym_ready = 1'b1;
            r.symbol = sym_table[idx[SYMBOL_BITS-1:0]];
          end else begin
            r.bad = 1'b1;
          end
          restart_walk();
        end else begin
          nb = walk_base + cnt;
          nf = (longint'(walk_first) + cnt) << 1;
          if (nb > BASE_CAP) nb = BASE_CAP;
          if (nf > FIRST_CAP) nf = FIRST_CAP;
          // give up when the code is too long or no symbol is left deeper down
          if (depth >= MAX_CODE_LEN || nb >= sym_loaded) begin
            r.bad = 1'b1;
            restart_walk();
          end else begin
            walk_code = code[WALK_BITS-1:0];
            walk_first = nf[WALK_BITS-1:0];
            walk_base = nb[COUNT_BITS-1:0];
            walk_depth = depth[LEN_BITS-1:0];
          end
        end
      end
      chbd_pkg::KIND_RESTART: restart_walk();
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_failure(input string what, input logic [SYMBOL_BITS-1:0] want,
                              input logic [SYMBOL_BITS-1:0] got);
    fail_count++;
    $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : scoreboard
    beat_t   seen;
    result_t want;
    if (!rst_ni) begin
      clear_tables();
    end else begin
      if (in_valid_i && in_ready_o) begin
        seen.kind = kind_i;
        seen.len = code_length_i;
        seen.cnt = length_count_i;
        seen.sym = symbol_in_i;
        seen.code_bit = code_bit_i;
        expected_decodes = {expected_decodes, decode_step(seen)};
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_decodes.size() == 0) begin
          fail_count++;
          $display("%0t ns: result beat expected none, got ready %0b symbol 0x%0h bad %0b",
                   $time, symbol_ready_o, symbol_out_o, bad_code_o);
        end else begin
          want = expected_decodes.pop_front();
          if (want.sym_ready !== symbol_ready_o)
            note_failure("symbol_ready", want.sym_ready, symbol_ready_o);
          if (want.symbol !== symbol_out_o)
            note_failure("symbol_out", want.symbol, symbol_out_o);
          if (want.bad !== bad_code_o)
            note_failure("bad_code", want.bad, bad_code_o);
        end
      end
    end
  end

  initial begin : sink_driver
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        out_ready_i = 1'b0;
        sink_hold_cycles--;
      end else begin
        out_ready_i = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Offer one beat and hold it until accepted; fields the kind ignores get noise.
  task automatic send_beat(input logic [KIND_BITS-1:0] kind, input logic [LEN_BITS-1:0] len,
                           input logic [COUNT_BITS-1:0] cnt,
                           input logic [SYMBOL_BITS-1:0] sym, input logic cbit);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    code_length_i = (kind == chbd_pkg::KIND_SET_COUNT) ? len :
                    LEN_BITS'($urandom_range((1 << LEN_BITS) - 1));
    length_count_i = (kind == chbd_pkg::KIND_SET_COUNT) ? cnt :
                     COUNT_BITS'($urandom_range((1 << COUNT_BITS) - 1));
    symbol_in_i = (kind == chbd_pkg::KIND_APPEND) ? sym :
                  SYMBOL_BITS'($urandom_range(TABLE_DEPTH - 1));
    code_bit_i = (kind == chbd_pkg::KIND_BIT) ? cbit : 1'($urandom_range(1));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (kind <= chbd_pkg::KIND_RESTART) beats_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_decodes.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_counts();
    gen_codes = 0;
    for (int n = 1; n <= MAX_CODE_LEN; n++) begin
      if (gen_count[n] != 0 || $urandom_range(7) == 0)
        send_beat(chbd_pkg::KIND_SET_COUNT, LEN_BITS'(n), COUNT_BITS'(gen_count[n]), 0, 0);
      gen_codes += gen_count[n];
    end
  endtask

  // Send the canonical code of symbol position k, most significant bit first.
  task automatic send_code(input int k);
    longint unsigned first_val, base_val, code_val;
    int code_len;
    first_val = 0;
    base_val = 0;
    code_val = 0;
    code_len = 0;
    for (int n = 1; n <= MAX_CODE_LEN && code_len == 0; n++) begin
      if (k < base_val + gen_count[n]) begin
        code_len = n;
        code_val = first_val + (k - base_val);
      end else begin
        first_val = (first_val + gen_count[n]) << 1;
        base_val += gen_count[n];
      end
    end
    for (int i = code_len - 1; i >= 0; i--)
      send_beat(chbd_pkg::KIND_BIT, 0, 0, 0, code_val[i]);
  endtask

  task automatic send_noise();
    case ($urandom_range(4))
      0: send_beat(chbd_pkg::KIND_RESTART, 0, 0, 0, 0);
      1: send_beat(KIND_BITS'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO)), 0, 0, 0, 0);
      2: send_beat(chbd_pkg::KIND_SET_COUNT,
                   LEN_BITS'($urandom_range(1) ? 0 :
                             $urandom_range((1 << LEN_BITS) - 1, MAX_CODE_LEN + 1)),
                   COUNT_BITS'($urandom_range((1 << COUNT_BITS) - 1)), 0, 0);
      default: send_beat(chbd_pkg::KIND_BIT, 0, 0, 0, 1'($urandom_range(1)));
    endcase
  endtask

  // Build a prefix-free length table, sometimes spoiled, and load it.
  task automatic load_code_table();
    longint free_slots;
    int left, max_len, style, c, total, n_append;
    style = $urandom_range(9);
    max_len = ($urandom_range(7) == 0) ? MAX_CODE_LEN : $urandom_range(6, 1);
    left = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(16, 1);
    free_slots = 1;
    total = 0;
    for (int n = 1; n <= MAX_CODE_LEN; n++) begin
      gen_count[n] = 0;
      if (n <= max_len) begin
        free_slots = free_slots * 2;
        c = (left < free_slots) ? left : int'(free_slots);
        if (n < max_len) c = $urandom_range(c / 2);
        gen_count[n] = c;
        left -= c;
        free_slots -= c;
        total += c;
      end
    end
    n_append = total;
    if (style == 0) gen_count[$urandom_range(max_len, 1)] = $urandom_range(BASE_CAP);
    if (style == 1) n_append = total + int'($urandom_range(6)) - 3;
    if (n_append < 0) n_append = 0;
    send_beat(chbd_pkg::KIND_CLEAR, 0, 0, 0, 0);
    send_counts();
    repeat (n_append)
      send_beat(chbd_pkg::KIND_APPEND, 0, 0, SYMBOL_BITS'($urandom_range(TABLE_DEPTH - 1)), 0);
  endtask

  task automatic test_reset_state();
    send_beat(chbd_pkg::KIND_BIT, 0, 0, 0, 1'b0);
    send_beat(chbd_pkg::KIND_BIT, 0, 0, 0, 1'b1);
    for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++) send_beat(KIND_BITS'(k), 0, 0, 0, 0);
    send_beat(chbd_pkg::KIND_RESTART, 0, 0, 0, 0);
  endtask

  task automatic test_small_table();
    foreach (gen_count[n]) gen_count[n] = 0;
    gen_count[1] = 1;
    gen_count[2] = 1;
    gen_count[3] = 2;
    send_beat(chbd_pkg::KIND_CLEAR, 0, 0, 0, 0);
    // lengths outside the table are dropped
    send_beat(chbd_pkg::KIND_SET_COUNT, 0, 1, 0, 0);
    send_beat(chbd_pkg::KIND_SET_COUNT, LEN_BITS'(MAX_CODE_LEN + 1), 1, 0, 0);
    send_beat(chbd_pkg::KIND_SET_COUNT, LEN_BITS'((1 << LEN_BITS) - 1), 1, 0, 0);
    send_counts();
    send_beat(chbd_pkg::KIND_APPEND, 0, 0, 0, 0);
    send_beat(chbd_pkg::KIND_APPEND, 0, 0, SYMBOL_BITS'(TABLE_DEPTH - 1), 0);
    send_beat(chbd_pkg::KIND_APPEND, 0, 0, 'h0AA, 0);
    send_beat(chbd_pkg::KIND_APPEND, 0, 0, 'h155, 0);
    for (int k = 0; k < 4; k++) send_code(k);
    send_beat(chbd_pkg::KIND_BIT, 0, 0, 0, 1'b1);
    send_beat(chbd_pkg::KIND_RESTART, 0, 0, 0, 0);
    send_code(0);
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    foreach (gen_count[n]) gen_count[n] = 0;
    gen_count[2] = 3;
    gen_count[3] = 2;
    send_beat(chbd_pkg::KIND_CLEAR, 0, 0, 0, 0);
    send_counts();
    repeat (5)
      send_beat(chbd_pkg::KIND_APPEND, 0, 0, SYMBOL_BITS'($urandom_range(TABLE_DEPTH - 1)), 0);
    wait_drain();
    // stall the result side while bits keep coming
    sink_hold_cycles = HOLD_CYCLES;
    repeat (25) send_code($urandom_range(4));
    wait_drain();
    src_idle_pct = 27;
  endtask

  task automatic test_table_full();
    send_beat(chbd_pkg::KIND_CLEAR, 0, 0, 0, 0);
    repeat (TABLE_DEPTH + 1)
      send_beat(chbd_pkg::KIND_APPEND, 0, 0, SYMBOL_BITS'($urandom_range(TABLE_DEPTH - 1)), 0);
    foreach (gen_count[n]) gen_count[n] = 0;
    gen_count[SYMBOL_BITS] = TABLE_DEPTH;
    send_counts();
    send_code(0);
    send_code(TABLE_DEPTH - 1);
    repeat (15) send_code($urandom_range(TABLE_DEPTH - 1));
    // oversubscribe the code space
    send_beat(chbd_pkg::KIND_SET_COUNT, 3, COUNT_BITS'(BASE_CAP), 0, 0);
    send_beat(chbd_pkg::KIND_SET_COUNT, LEN_BITS'(MAX_CODE_LEN), COUNT_BITS'(TABLE_DEPTH), 0, 0);
    repeat (20) send_beat(chbd_pkg::KIND_BIT, 0, 0, 0, 1'($urandom_range(1)));
    wait_drain();
  endtask

  task automatic run_random_phase(input int src_pct, input int sink_pct, input int n_items);
    int start;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    start = beats_sent;
    while (beats_sent - start < n_items) begin
      load_code_table();
      repeat ($urandom_range(24, 6)) begin
        if (gen_codes == 0 || $urandom_range(9) == 0) send_noise();
        else send_code($urandom_range(gen_codes - 1));
      end
    end
    wait_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = chbd_pkg::KIND_RESTART;
    code_length_i = '0;
    length_count_i = '0;
    symbol_in_i = '0;
    code_bit_i = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_small_table();
    test_backpressure();
    test_table_full();
    run_random_phase(27, 64, 110);
    run_random_phase(64, 27, 110);
    run_random_phase(0, 0, 110);

    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
